@@ rtl/core/dcc_pkg.sv @@
// shared types and constants of the dwell click controller
package dcc_pkg;

   // field widths fixed by the register map and the transaction formats
   localparam int DWELL_BITS     = 7;
   localparam int DRAG_BITS      = 7;
   localparam int MOVE_BITS      = 8;
   localparam int SUM_BITS       = DWELL_BITS + 1;
   localparam int STROKE_BITS    = 2;
   localparam int ACTION_BITS    = 3;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 8;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RUNNING     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DWELL_TICKS = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DRAG_TICKS  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_MOVE    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SMART_DRAG  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STROKES     = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOUND       = 3'd6;

   // register reset values
   localparam logic [DWELL_BITS-1:0] DWELL_RESET = 7'd5;
   localparam logic [DRAG_BITS-1:0]  DRAG_RESET  = 7'd3;
   localparam logic [MOVE_BITS-1:0]  MOVE_RESET  = 8'd5;

   // pointer action codes
   typedef enum logic [ACTION_BITS-1:0] {
      ACT_NONE    = 3'd0,
      ACT_CLICK   = 3'd1,
      ACT_PRESS   = 3'd2,
      ACT_RELEASE = 3'd3,
      ACT_RIGHT   = 3'd4,
      ACT_DOUBLE  = 3'd5
   } action_type;

   // stroke classes
   typedef enum logic [STROKE_BITS-1:0] {
      STROKE_NORMAL   = 2'd0,
      STROKE_SUPPRESS = 2'd1,
      STROKE_RIGHT    = 2'd2,
      STROKE_DOUBLE   = 2'd3
   } stroke_type;

   // configuration register contents
   typedef struct packed {
      logic                  running;
      logic [DWELL_BITS-1:0] dwell_ticks;
      logic [DRAG_BITS-1:0]  drag_ticks;
      logic [MOVE_BITS-1:0]  min_movement;
      logic                  smart_drag_enable;
      logic                  strokes_enable;
      logic                  sound_enable;
   } cfg_type;

endpackage

@@ rtl/core/dcc_req_if.sv @@
// request channel carrying one pointer sample per transaction
interface dcc_req_if #(
   parameter int COORD_BITS = 12
);
   logic                               valid;
   logic                               ready;
   logic [COORD_BITS-1:0]              pointer_x;
   logic [COORD_BITS-1:0]              pointer_y;
   logic [dcc_pkg::STROKE_BITS-1:0]    stroke_class;

   modport source (output valid, output pointer_x, output pointer_y,
                   output stroke_class, input ready);
   modport sink   (input valid, input pointer_x, input pointer_y,
                   input stroke_class, output ready);
endinterface

@@ rtl/core/dcc_rsp_if.sv @@
// response channel carrying one pointer action per transaction
interface dcc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [dcc_pkg::ACTION_BITS-1:0] action;
   logic                            sound_pulse;

   modport source (output valid, output action, output sound_pulse, input ready);
   modport sink   (input valid, input action, input sound_pulse, output ready);
endinterface

@@ rtl/core/dcc_csr_regs.sv @@
// configuration register file with a reload strobe after every valid write
module dcc_csr_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [dcc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [dcc_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output dcc_pkg::cfg_type                    cfg,
   output logic                                reload
);
   dcc_pkg::cfg_type cfg_ff, cfg_in;
   logic             reload_ff, reload_in;

   // write decode, indexes past the map are ignored
   always_comb begin
      cfg_in    = cfg_ff;
      reload_in = 1'b0;
      if (csr_we) begin
         reload_in = 1'b1;
         unique case (csr_index)
            dcc_pkg::CSR_RUNNING:     cfg_in.running = csr_wdata[0];
            dcc_pkg::CSR_DWELL_TICKS:
               cfg_in.dwell_ticks = csr_wdata[dcc_pkg::DWELL_BITS-1:0];
            dcc_pkg::CSR_DRAG_TICKS:
               cfg_in.drag_ticks = csr_wdata[dcc_pkg::DRAG_BITS-1:0];
            dcc_pkg::CSR_MIN_MOVE:
               cfg_in.min_movement = csr_wdata[dcc_pkg::MOVE_BITS-1:0];
            dcc_pkg::CSR_SMART_DRAG:  cfg_in.smart_drag_enable = csr_wdata[0];
            dcc_pkg::CSR_STROKES:     cfg_in.strokes_enable = csr_wdata[0];
            dcc_pkg::CSR_SOUND:       cfg_in.sound_enable = csr_wdata[0];
            default:                  reload_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.running           <= 1'b0;
         cfg_ff.dwell_ticks       <= dcc_pkg::DWELL_RESET;
         cfg_ff.drag_ticks        <= dcc_pkg::DRAG_RESET;
         cfg_ff.min_movement      <= dcc_pkg::MOVE_RESET;
         cfg_ff.smart_drag_enable <= 1'b0;
         cfg_ff.strokes_enable    <= 1'b0;
         cfg_ff.sound_enable      <= 1'b0;
         reload_ff                <= 1'b0;
      end else begin
         cfg_ff    <= cfg_in;
         reload_ff <= reload_in;
      end
   end

   assign cfg    = cfg_ff;
   assign reload = reload_ff;
endmodule

@@ rtl/core/dcc_in_stage.sv @@
// input register for pointer samples
module dcc_in_stage #(
   parameter int COORD_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   dcc_req_if.sink                           req,
   input  logic                              advance,
   output logic                              smp_valid,
   output logic [COORD_BITS-1:0]             smp_x,
   output logic [COORD_BITS-1:0]             smp_y,
   output logic [dcc_pkg::STROKE_BITS-1:0]   smp_class
);
   logic                            valid_ff, valid_in;
   logic [COORD_BITS-1:0]           x_ff, y_ff;
   logic [dcc_pkg::STROKE_BITS-1:0] class_ff;
   logic                            accept;

   // free when empty or when the held sample moves on this cycle
   assign req.ready = !valid_ff || advance;
   assign accept    = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept)
         valid_in = 1'b1;
      else if (advance)
         valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff     <= req.pointer_x;
         y_ff     <= req.pointer_y;
         class_ff <= req.stroke_class;
      end
   end

   assign smp_valid = valid_ff;
   assign smp_x     = x_ff;
   assign smp_y     = y_ff;
   assign smp_class = class_ff;
endmodule

@@ rtl/core/dcc_dwell_engine.sv @@
// motion detection, dwell counting, action choice and the result register
module dcc_dwell_engine #(
   parameter int COORD_BITS = 12,
   parameter int TICK_BITS  = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dcc_pkg::cfg_type                  cfg,
   input  logic                              reload,
   input  logic                              smp_valid,
   input  logic [COORD_BITS-1:0]             smp_x,
   input  logic [COORD_BITS-1:0]             smp_y,
   input  logic [dcc_pkg::STROKE_BITS-1:0]   smp_class,
   output logic                              advance,
   dcc_rsp_if.source                         rsp
);
   localparam int AW   = COORD_BITS + 1;
   localparam int DW   = COORD_BITS + 2;
   localparam int CMPW = (TICK_BITS > dcc_pkg::SUM_BITS) ? TICK_BITS : dcc_pkg::SUM_BITS;

   logic signed [AW-1:0]  anchor_x_ff, anchor_x_in, anchor_y_ff, anchor_y_in;
   logic [TICK_BITS-1:0]  still_ff, still_in;
   logic                  moving_ff, moving_in;
   logic                  started_ff, started_in;
   logic                  held_ff, held_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   dcc_pkg::action_type   action_ff, act;
   logic                  sound_ff, snd;

   logic                          take;
   logic [dcc_pkg::SUM_BITS-1:0]  sum;
   logic [CMPW-1:0]               sum_w, lim_w;
   logic [TICK_BITS-1:0]          ceil_val, still_cur, still_inc;
   logic [dcc_pkg::MOVE_BITS-1:0] thr;
   logic signed [DW-1:0]          dx, dy;
   logic [DW-1:0]                 adx, ady, thr_w;
   logic                          motion, plain;

   // result register frees when empty or taken
   assign advance = !rsp_valid_ff || rsp.ready;
   assign take    = smp_valid && advance;

   // tick ceiling, saturated to the counter range
   assign sum      = {1'b0, cfg.dwell_ticks} + {1'b0, cfg.drag_ticks};
   assign sum_w    = CMPW'(sum);
   assign lim_w    = CMPW'({TICK_BITS{1'b1}});
   assign ceil_val = (sum_w > lim_w) ? {TICK_BITS{1'b1}} : sum_w[TICK_BITS-1:0];

   // displacement against the anchor, threshold with hysteresis
   assign thr   = moving_ff ? dcc_pkg::MOVE_BITS'(1) : cfg.min_movement;
   assign thr_w = DW'(thr);
   assign dx    = $signed({2'b00, smp_x}) - $signed({anchor_x_ff[AW-1], anchor_x_ff});
   assign dy    = $signed({2'b00, smp_y}) - $signed({anchor_y_ff[AW-1], anchor_y_ff});
   assign adx   = dx[DW-1] ? DW'(-dx) : DW'(dx);
   assign ady   = dy[DW-1] ? DW'(-dy) : DW'(dy);
   assign motion = (adx >= thr_w) || (ady >= thr_w);

   // a pending reload counts as already applied for the tick
   assign still_cur = reload ? ceil_val : still_ff;
   assign still_inc = (still_cur < ceil_val) ? still_cur + TICK_BITS'(1) : still_cur;
   assign plain     = held_ff || !cfg.strokes_enable
                      || (dcc_pkg::stroke_type'(smp_class) == dcc_pkg::STROKE_NORMAL);

   // per-tick state update and action choice
   always_comb begin
      anchor_x_in = anchor_x_ff;
      anchor_y_in = anchor_y_ff;
      still_in    = still_cur;
      moving_in   = moving_ff;
      started_in  = started_ff;
      held_in     = held_ff;
      act         = dcc_pkg::ACT_NONE;
      snd         = 1'b0;
      if (take && cfg.running) begin
         moving_in = motion;
         if (motion) begin
            anchor_x_in = $signed({1'b0, smp_x});
            anchor_y_in = $signed({1'b0, smp_y});
            if (started_ff) begin
               started_in = 1'b0;
               still_in   = ceil_val;
            end else begin
               still_in = '0;
            end
         end else begin
            still_in = still_inc;
            if (CMPW'(still_inc) == CMPW'(cfg.dwell_ticks)) begin
               if (plain) begin
                  // normal click path, smart drag alternates press and release
                  priority if (cfg.smart_drag_enable && !held_ff) begin
                     act      = dcc_pkg::ACT_PRESS;
                     held_in  = 1'b1;
                     still_in = '0;
                     snd      = cfg.sound_enable;
                  end else if (cfg.smart_drag_enable) begin
                     act      = dcc_pkg::ACT_RELEASE;
                     held_in  = 1'b0;
                     still_in = ceil_val;
                  end else begin
                     act = dcc_pkg::ACT_CLICK;
                     snd = cfg.sound_enable;
                  end
               end else begin
                  unique case (dcc_pkg::stroke_type'(smp_class))
                     dcc_pkg::STROKE_RIGHT:  act = dcc_pkg::ACT_RIGHT;
                     dcc_pkg::STROKE_DOUBLE: act = dcc_pkg::ACT_DOUBLE;
                     default:                act = dcc_pkg::ACT_NONE;
                  endcase
               end
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = advance ? take : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_x_ff  <= '1;
         anchor_y_ff  <= '1;
         still_ff     <= '0;
         moving_ff    <= 1'b0;
         started_ff   <= 1'b1;
         held_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         anchor_x_ff  <= anchor_x_in;
         anchor_y_ff  <= anchor_y_in;
         still_ff     <= still_in;
         moving_ff    <= moving_in;
         started_ff   <= started_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (take) begin
         action_ff <= act;
         sound_ff  <= snd;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.action      = action_ff;
   assign rsp.sound_pulse = sound_ff;

   // sound only goes with a click or a press
   a_sound_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && sound_ff |->
         (action_ff == dcc_pkg::ACT_CLICK) || (action_ff == dcc_pkg::ACT_PRESS))
      else $error("sound pulse on an action that is neither click nor press");

   // a shown press or release matches the button state
   a_press_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (action_ff == dcc_pkg::ACT_PRESS) |-> held_ff)
      else $error("press shown but button not held");

   a_release_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (action_ff == dcc_pkg::ACT_RELEASE) |-> !held_ff)
      else $error("release shown but button still held");

   // the still counter stays within the ceiling once settled
   a_still_bound: assert property (@(posedge clock) disable iff (reset)
      !reload |-> (still_ff <= ceil_val))
      else $error("still tick count above ceiling");

   // a stopped tool reports no action
   a_stopped_none: assert property (@(posedge clock) disable iff (reset)
      take && !cfg.running |=> (action_ff == dcc_pkg::ACT_NONE) && !sound_ff)
      else $error("action reported while stopped");
endmodule

@@ rtl/core/dwell_click_controller.sv @@
// top level of the dwell click controller
// One pointer sample per transaction on req_chan gives exactly one action on rsp_chan.
// Samples are taken one per clock cycle with no gaps while rsp_chan.ready is high; a
// result is registered in the result register once its sample has left the input
// register, and can be taken from there. The input register and the result register
// decouple the two sides, with req_chan.ready following rsp_chan.ready through the
// result register's free condition. Any write to a defined register reloads the still
// tick counter to the tick ceiling via the registered reload strobe; writes must be
// made only while no sample is in flight; the block itself does not enforce this.
module dwell_click_controller #(
   parameter int COORD_BITS = 12,
   parameter int TICK_BITS  = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   dcc_req_if.sink                             req_chan,
   dcc_rsp_if.source                           rsp_chan,
   input  logic                                csr_we,
   input  logic [dcc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [dcc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   dcc_pkg::cfg_type                cfg;
   logic                            reload;
   logic                            advance;
   logic                            smp_valid;
   logic [COORD_BITS-1:0]           smp_x, smp_y;
   logic [dcc_pkg::STROKE_BITS-1:0] smp_class;

   dcc_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .reload    (reload)
   );

   dcc_in_stage #(
      .COORD_BITS (COORD_BITS)
   ) u_in (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .advance   (advance),
      .smp_valid (smp_valid),
      .smp_x     (smp_x),
      .smp_y     (smp_y),
      .smp_class (smp_class)
   );

   dcc_dwell_engine #(
      .COORD_BITS (COORD_BITS),
      .TICK_BITS  (TICK_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .reload    (reload),
      .smp_valid (smp_valid),
      .smp_x     (smp_x),
      .smp_y     (smp_y),
      .smp_class (smp_class),
      .advance   (advance),
      .rsp       (rsp_chan)
   );
endmodule

@@ sim/dwell_click_controller_tb.sv @@
// self-checking testbench of the dwell click controller
`timescale 1ns / 100ps

module dwell_click_controller_tb;
   import dcc_pkg::*;

   localparam int COORD_W      = 12;
   localparam int TICK_W       = 8;
   localparam int COORD_MAX    = (1 << COORD_W) - 1;
   localparam int CLOCK_PERIOD = 12;
   localparam int RANDOM_ITEMS = 1300;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 3'd7;

   // one predicted result transaction
   typedef struct {
      action_type action;
      logic       sound;
   } action_rec;

   // mirrors the controller state and holds the actions still owed by the block
   class action_scoreboard;
      cfg_type           regs;
      int                anchor_x;
      int                anchor_y;
      logic [TICK_W-1:0] still_count;
      bit                moving;
      bit                just_started;
      bit                button_held;
      int                checked;
      action_rec         expected_actions[$];

      function void clear();
         regs              = '0;
         regs.dwell_ticks  = DWELL_RESET;
         regs.drag_ticks   = DRAG_RESET;
         regs.min_movement = MOVE_RESET;
         anchor_x          = -1;
         anchor_y          = -1;
         still_count       = '0;
         moving            = 1'b0;
         just_started      = 1'b1;
         button_held       = 1'b0;
         checked           = 0;
         expected_actions.delete();
      endfunction

      function int pending();
         return expected_actions.size();
      endfunction

      // dwell plus drag ticks, saturated to the counter width
      function logic [TICK_W-1:0] tick_ceiling();
         int sum;
         sum = int'(regs.dwell_ticks) + int'(regs.drag_ticks);
         if (sum > (1 << TICK_W) - 1) sum = (1 << TICK_W) - 1;
         return sum[TICK_W-1:0];
      endfunction

      // any defined register reloads the still count from the new ceiling
      function void write_reg(logic [CSR_INDEX_BITS-1:0] index,
                              logic [CSR_DATA_BITS-1:0] data);
         case (index)
            CSR_RUNNING:     regs.running           = data[0];
            CSR_DWELL_TICKS: regs.dwell_ticks       = data[DWELL_BITS-1:0];
            CSR_DRAG_TICKS:  regs.drag_ticks        = data[DRAG_BITS-1:0];
            CSR_MIN_MOVE:    regs.min_movement      = data[MOVE_BITS-1:0];
            CSR_SMART_DRAG:  regs.smart_drag_enable = data[0];
            CSR_STROKES:     regs.strokes_enable    = data[0];
            CSR_SOUND:       regs.sound_enable      = data[0];
            default:         return;
         endcase
         still_count = tick_ceiling();
      endfunction

      // one pointer sample in, one predicted action queued
      function void note_sample(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                stroke_type cls);
         action_rec         rec;
         logic [TICK_W-1:0] limit;
         int                thr;
         int                dx;
         int                dy;
         rec.action = ACT_NONE;
         rec.sound  = 1'b0;
         if (regs.running) begin
            limit = tick_ceiling();
            // hysteresis: a still pointer needs min_movement, a moving one any change
            thr = moving ? 1 : int'(regs.min_movement);
            dx  = int'(x) - anchor_x;
            dy  = int'(y) - anchor_y;
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            moving = (dx >= thr) || (dy >= thr);
            if (moving) begin
               anchor_x = int'(x);
               anchor_y = int'(y);
               if (just_started) begin
                  just_started = 1'b0;
                  still_count  = limit;
               end else begin
                  still_count = '0;
               end
            end else begin
               if (still_count < limit) still_count++;
               if (still_count == {1'b0, regs.dwell_ticks}) begin
                  if (button_held || !regs.strokes_enable || cls == STROKE_NORMAL) begin
                     // normal dwell path: click, or press and release in smart drag
                     if (!regs.smart_drag_enable) begin
                        rec.action = ACT_CLICK;
                        rec.sound  = regs.sound_enable;
                     end else if (!button_held) begin
                        rec.action  = ACT_PRESS;
                        rec.sound   = regs.sound_enable;
                        button_held = 1'b1;
                        still_count = '0;
                     end else begin
                        rec.action  = ACT_RELEASE;
                        button_held = 1'b0;
                        still_count = limit;
                     end
                  end else if (cls == STROKE_RIGHT) begin
                     rec.action = ACT_RIGHT;
                  end else if (cls == STROKE_DOUBLE) begin
                     rec.action = ACT_DOUBLE;
                  end
               end
            end
         end
         expected_actions.push_back(rec);
      endfunction

      // compares one result transaction with the oldest prediction
      function string check_action(logic [ACTION_BITS-1:0] act, logic snd);
         action_rec rec;
         string     msg;
         checked++;
         if (expected_actions.size() == 0)
            return $sformatf("result %0d: action %0d sound %0d with nothing expected",
                             checked, act, snd);
         rec = expected_actions.pop_front();
         msg = "";
         if (act !== rec.action)
            msg = $sformatf("%s action %0d expected %0d", msg, act, rec.action);
         if (snd !== rec.sound)
            msg = $sformatf("%s sound_pulse %0d expected %0d", msg, snd, rec.sound);
         if (msg != "") msg = $sformatf("result %0d:%s", checked, msg);
         return msg;
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   dcc_req_if #(.COORD_BITS(COORD_W)) sample_bus ();
   dcc_rsp_if                         action_bus ();

   action_scoreboard sb;
   int               mismatch_count;
   int               random_count;
   bit               steady;
   string            fault;

   dwell_click_controller #(
      .COORD_BITS (COORD_W),
      .TICK_BITS  (TICK_W)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (sample_bus),
      .rsp_chan  (action_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("dwell_click_controller regression: fail");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("mismatch: %s", msg);
   endtask

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // present one sample after a random gap and hold it until accepted
   task automatic send_sample(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input stroke_type cls);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         sample_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      sample_bus.valid        = 1'b1;
      sample_bus.pointer_x    = x;
      sample_bus.pointer_y    = y;
      sample_bus.stroke_class = cls;
      do @(posedge clock); while (sample_bus.ready !== 1'b1);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(posedge clock);
      sb.write_reg(index, data);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // stop sending and wait until every owed action has come back
   task automatic settle();
      @(negedge clock);
      sample_bus.valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // accepted transactions on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (action_bus.valid === 1'b1 && action_bus.ready === 1'b1) begin
            fault = sb.check_action(action_bus.action, action_bus.sound_pulse);
            if (fault != "") report_mismatch(fault);
         end
         if (sample_bus.valid === 1'b1 && sample_bus.ready === 1'b1)
            sb.note_sample(sample_bus.pointer_x, sample_bus.pointer_y,
                           stroke_type'(sample_bus.stroke_class));
      end
   end

   // result side: bursts of ready broken by stalls
   initial begin
      int burst;
      int stall;
      action_bus.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         action_bus.ready = 1'b1;
         burst = $urandom_range(1, 8);
         repeat (burst - 1) @(negedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            @(negedge clock);
            action_bus.ready = 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
      end
   end

   // stimulus
   initial begin
      logic [CSR_DATA_BITS-1:0] data;
      logic [DWELL_BITS-1:0]    dwell;
      logic [TICK_W-1:0]        lim;
      stroke_type               cls;
      bit                       first_phase;
      int                       r;
      int                       target;
      int                       sent;
      int                       n;
      int                       len;
      int                       span;
      int                       px;
      int                       py;
      int                       jx;
      int                       jy;

      sb = new;
      sb.clear();
      mismatch_count          = 0;
      random_count            = 0;
      steady                  = 1'b0;
      reset                   = 1'b1;
      csr_we                  = 1'b0;
      csr_index               = CSR_RUNNING;
      csr_wdata               = '0;
      sample_bus.valid        = 1'b0;
      sample_bus.pointer_x    = '0;
      sample_bus.pointer_y    = '0;
      sample_bus.stroke_class = STROKE_NORMAL;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // tool stopped after reset: nothing happens
      send_sample(12'(0), 12'(0), STROKE_NORMAL);
      send_sample(12'(COORD_MAX), 12'(COORD_MAX), STROKE_DOUBLE);
      settle();
      write_csr(CSR_RUNNING, 8'hFF);
      write_csr(CSR_SOUND, 8'h01);
      write_csr(CSR_STROKES, 8'h01);

      // first sample is no motion, the first move jumps to the ceiling, no right click follows
      send_sample(12'(0), 12'(0), STROKE_NORMAL);
      send_sample(12'(COORD_MAX), 12'(0), STROKE_NORMAL);
      repeat (4) send_sample(12'(COORD_MAX), 12'(0), STROKE_SUPPRESS);
      send_sample(12'(COORD_MAX), 12'(0), STROKE_RIGHT);

      // jitter below the threshold keeps the pointer still, dwell ends in a double click
      send_sample(12'(0), 12'(COORD_MAX), STROKE_NORMAL);
      send_sample(12'(0), 12'(COORD_MAX), STROKE_NORMAL);
      send_sample(12'(4), 12'(COORD_MAX - 4), STROKE_NORMAL);
      send_sample(12'(0), 12'(COORD_MAX), STROKE_NORMAL);
      send_sample(12'(3), 12'(COORD_MAX), STROKE_NORMAL);
      send_sample(12'(0), 12'(COORD_MAX), STROKE_DOUBLE);
      settle();

      // smart drag with one tick dwell and no drag: press, release past strokes, suppress, press
      write_csr(CSR_DWELL_TICKS, 8'h81);
      write_csr(CSR_DRAG_TICKS, 8'h80);
      write_csr(CSR_SMART_DRAG, 8'h01);
      send_sample(12'(0), 12'(COORD_MAX), STROKE_NORMAL);
      send_sample(12'(0), 12'(COORD_MAX), STROKE_RIGHT);
      send_sample(12'(0), 12'(COORD_MAX), STROKE_SUPPRESS);
      send_sample(12'(0), 12'(COORD_MAX), STROKE_NORMAL);
      settle();

      // zero dwell with zero ceiling and zero threshold, button still held
      write_csr(CSR_DWELL_TICKS, 8'h00);
      write_csr(CSR_MIN_MOVE, 8'h00);
      write_csr(CSR_SMART_DRAG, 8'h00);
      send_sample(12'(0), 12'(COORD_MAX), STROKE_NORMAL);
      send_sample(12'(0), 12'(COORD_MAX), STROKE_DOUBLE);
      send_sample(12'(0), 12'(COORD_MAX), STROKE_RIGHT);

      // random phases, each with its own register setting
      first_phase = 1'b1;
      while (random_count < RANDOM_ITEMS) begin
         settle();
         steady = 1'b0;

         if (first_phase || $urandom_range(0, 99) < 60) begin
            data    = 8'($urandom);
            data[0] = ($urandom_range(0, 99) >= 8);
            write_csr(CSR_RUNNING, data);
         end
         if (first_phase || $urandom_range(0, 99) < 60) begin
            r = $urandom_range(0, 99);
            if (r < 5)       dwell = 7'd0;
            else if (r < 10) dwell = 7'd100;
            else if (r < 13) dwell = 7'd127;
            else             dwell = 7'($urandom_range(1, 6));
            data                   = 8'($urandom);
            data[DWELL_BITS-1:0]   = dwell;
            write_csr(CSR_DWELL_TICKS, data);
         end
         if (first_phase || $urandom_range(0, 99) < 60) begin
            r    = $urandom_range(0, 99);
            data = 8'($urandom);
            if (r < 15)      data[DRAG_BITS-1:0] = 7'd0;
            else if (r < 22) data[DRAG_BITS-1:0] = 7'd100;
            else if (r < 25) data[DRAG_BITS-1:0] = 7'd127;
            else             data[DRAG_BITS-1:0] = 7'($urandom_range(1, 4));
            write_csr(CSR_DRAG_TICKS, data);
         end
         if (first_phase || $urandom_range(0, 99) < 60) begin
            r = $urandom_range(0, 99);
            if (r < 10)      data = 8'd0;
            else if (r < 20) data = 8'd255;
            else if (r < 30) data = 8'd1;
            else             data = 8'($urandom_range(2, 12));
            write_csr(CSR_MIN_MOVE, data);
         end
         if (first_phase || $urandom_range(0, 99) < 60) begin
            data = 8'($urandom);
            write_csr(CSR_SMART_DRAG, data);
         end
         if (first_phase || $urandom_range(0, 99) < 60) begin
            data = 8'($urandom);
            write_csr(CSR_STROKES, data);
         end
         if (first_phase || $urandom_range(0, 99) < 60) begin
            data = 8'($urandom);
            write_csr(CSR_SOUND, data);
         end
         // undefined index must leave everything alone, still count included
         if ($urandom_range(0, 99) < 25) write_csr(CSR_UNUSED, 8'($urandom));
         first_phase = 1'b0;
         steady      = ($urandom_range(0, 4) == 0);

         // gestures: travel, arrive, then hover with jitter below the threshold
         target = $urandom_range(30, 120);
         sent   = 0;
         while (sent < target) begin
            if ($urandom_range(0, 99) < 12) begin
               n = $urandom_range(1, 4);
               repeat (n)
                  send_sample(12'($urandom), 12'($urandom),
                              stroke_type'(2'($urandom_range(0, 3))));
               sent += n;
            end else begin
               if ($urandom_range(0, 9) == 0) px = $urandom_range(0, 1) ? COORD_MAX : 0;
               else px = $urandom_range(0, COORD_MAX);
               if ($urandom_range(0, 9) == 0) py = $urandom_range(0, 1) ? COORD_MAX : 0;
               else py = $urandom_range(0, COORD_MAX);
               n = $urandom_range(0, 2);
               repeat (n)
                  send_sample(12'($urandom), 12'($urandom),
                              stroke_type'(2'($urandom_range(0, 3))));
               send_sample(12'(px), 12'(py), stroke_type'(2'($urandom_range(0, 3))));

               span  = (sb.regs.min_movement > 1) ? int'(sb.regs.min_movement) - 1 : 0;
               dwell = sb.regs.dwell_ticks;
               lim   = sb.tick_ceiling();
               if ($urandom_range(0, 1))
                  len = $urandom_range((dwell > 0) ? int'(dwell) - 1 : 0, int'(dwell) + 2);
               else
                  len = $urandom_range(0, (int'(lim) + 3 > 130) ? 130 : int'(lim) + 3);
               for (int i = 0; i < len; i++) begin
                  cls = stroke_type'(2'($urandom_range(0, 3)));
                  if (span == 0 || $urandom_range(0, 9) < 6) begin
                     send_sample(12'(px), 12'(py), cls);
                  end else begin
                     jx = px + $urandom_range(0, 2 * span) - span;
                     jy = py + $urandom_range(0, 2 * span) - span;
                     if (jx < 0) jx = 0;
                     if (jx > COORD_MAX) jx = COORD_MAX;
                     if (jy < 0) jy = 0;
                     if (jy > COORD_MAX) jy = COORD_MAX;
                     send_sample(12'(jx), 12'(jy), cls);
                  end
               end
               sent += n + 1 + len;
            end
            // occasional full drain with the sender held back
            if ($urandom_range(0, 99) < 3) settle();
         end
         random_count += sent;
      end

      settle();
      if (mismatch_count == 0)
         $display("dwell_click_controller regression: pass");
      else
         $display("dwell_click_controller regression: fail");
      $finish;
   end

endmodule

@@ dwell_click_controller.f @@
rtl/core/dcc_pkg.sv
rtl/core/dcc_req_if.sv
rtl/core/dcc_rsp_if.sv
rtl/core/dcc_csr_regs.sv
rtl/core/dcc_in_stage.sv
rtl/core/dcc_dwell_engine.sv
rtl/core/dwell_click_controller.sv
sim/dwell_click_controller_tb.sv
